// File: src/wvp_pkg.sv
// Package for the wireframe vertex projector: shared types and constants.
// No dependencies.
package wvp_pkg;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   // fixed-point one; the datapath divides and scales by shifting, so keep a power of two
   localparam int FIXED_ONE = 4096;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DEPTH,
      ST_DIVX,
      ST_DIVY,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load_item;
      logic       mac_start;
      logic       mac_step;
      logic       div_start;
      logic       div_sel_y;
      logic       div_step;
      logic       set_skip;
      logic       emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic       mac_last;
      logic       depth_bad;
      logic       div_last;
   } sts_type;

endpackage

// File: src/wvp_ctrl.sv
// Controller state machine for the vertex projector.
// Depends on wvp_pkg.
module wvp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output wvp_pkg::cmd_type cmd,
   input  wvp_pkg::sts_type sts
);
   import wvp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_op == OP_PROJECT) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.mac_last) state_in = ST_DEPTH;
         end
         ST_DEPTH: begin
            state_in = sts.depth_bad ? ST_IDLE : ST_DIVX;
         end
         ST_DIVX: begin
            if (sts.div_last) state_in = ST_DIVY;
         end
         ST_DIVY: begin
            if (sts.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      cmd.load_item = (state_ff == ST_IDLE) && req_tvalid && req_op == OP_LOAD;
      cmd.mac_start = (state_ff == ST_IDLE) && req_tvalid && req_op == OP_PROJECT;
      cmd.mac_step  = (state_ff == ST_MUL);
      cmd.set_skip  = (state_ff == ST_DEPTH) && sts.depth_bad;
      cmd.div_start = (state_ff == ST_DEPTH && !sts.depth_bad) ||
                      (state_ff == ST_DIVX && sts.div_last);
      cmd.div_sel_y = (state_ff == ST_DIVX);
      cmd.div_step  = (state_ff == ST_DIVX) || (state_ff == ST_DIVY);
      cmd.emit      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // hold result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.emit)   rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: src/wvp_datapath.sv
// Datapath: matrix store, shared multiply-accumulate, shared restoring divider.
// Depends on wvp_pkg.
module wvp_datapath (
   input  logic             clock,
   input  logic             reset,
   input  wvp_pkg::cmd_type cmd,
   output wvp_pkg::sts_type sts,
   input  logic [1:0]       matrix_row,
   input  logic [1:0]       matrix_col,
   input  logic [31:0]      matrix_value,
   input  logic [15:0]      vert_x,
   input  logic [15:0]      vert_y,
   input  logic [15:0]      vert_z,
   input  logic             jump_flag,
   input  logic [15:0]      density,
   output logic [80:0]      rsp_data
);
   import wvp_pkg::*;

   localparam int SH  = $clog2(FIXED_ONE);
   localparam int DW  = 32 + SH;   // dividend magnitude width
   localparam int CW  = $clog2(DW + 1);

   // matrix store, 12 registers; columns 0-2 are read at a counter-chosen place
   logic [31:0] mat_ff [12];
   logic        skip_ff, skip_in;

   // write one entry; row three is dropped
   always_ff @(posedge clock) begin
      if (cmd.load_item && matrix_row != 2'd3)
         mat_ff[{matrix_row, matrix_col}] <= matrix_value;
   end

   // multiply-accumulate: one product per cycle, nine products
   logic [15:0] vx_ff, vy_ff, vz_ff;
   logic        jump_ff;
   logic [1:0]  r_ff, c_ff;
   logic [31:0] acc_ff [3];
   logic [3:0]  idx;
   logic signed [15:0] vsel;
   logic signed [47:0] prod;
   logic signed [47:0] quo;

   assign idx  = {r_ff, c_ff};
   always_comb begin
      unique case (c_ff)
         2'd0:    vsel = vx_ff;
         2'd1:    vsel = vy_ff;
         default: vsel = vz_ff;
      endcase
   end
   assign prod = $signed(mat_ff[idx]) * vsel;
   // truncate toward zero by the fixed-point one
   assign quo  = (prod < 0) ? -((-prod) >>> SH) : (prod >>> SH);

   assign sts.mac_last = (r_ff == 2'd2) && (c_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (cmd.mac_start) begin
         vx_ff   <= vert_x;
         vy_ff   <= vert_y;
         vz_ff   <= vert_z;
         jump_ff <= jump_flag;
         r_ff    <= 2'd0;
         c_ff    <= 2'd0;
         for (int i = 0; i < 3; i++) acc_ff[i] <= mat_ff[4*i + 3];
      end else if (cmd.mac_step) begin
         acc_ff[r_ff] <= acc_ff[r_ff] + quo[31:0];
         if (c_ff == 2'd2) begin
            c_ff <= 2'd0;
            r_ff <= r_ff + 2'd1;
         end else begin
            c_ff <= c_ff + 2'd1;
         end
      end
   end

   assign sts.depth_bad = $signed(acc_ff[2]) <= 0;

   // restoring divider, one quotient bit per cycle
   logic [DW-1:0] rem_ff, num_ff;
   logic [31:0]   den_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;
   logic [32:0]   trial_hi;
   logic [DW:0]   shifted;
   logic [31:0]   sx_ff;
   logic [DW-1:0] qfin;
   logic [31:0]   half;
   logic signed [31:0] numsrc;

   assign numsrc   = cmd.div_sel_y ? acc_ff[1] : acc_ff[0];
   assign shifted  = {rem_ff, num_ff[DW-1]};
   assign trial_hi = shifted[32:0] - {1'b0, den_ff};
   assign sts.div_last = (cnt_ff == CW'(DW - 1));
   logic          fits;
   assign fits = (shifted[DW:33] != '0) || !trial_hi[32];
   logic [DW-1:0] rem_next;
   assign rem_next = fits ? DW'(shifted - {{(DW-32){1'b0}}, den_ff}) : shifted[DW-1:0];
   assign qfin = {num_ff[DW-2:0], fits};
   // halve magnitude, then apply sign
   assign half = qfin[32:1];

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         num_ff <= DW'((numsrc < 0) ? -$signed({numsrc[31], numsrc}) : {1'b0, numsrc}) << SH;
         neg_ff <= numsrc[31];
         den_ff <= acc_ff[2];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_next;
         num_ff <= {num_ff[DW-2:0], fits};
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.div_step && sts.div_last && cmd.div_sel_y)
         sx_ff <= neg_ff ? -half : half;
   end

   // skip flag
   always_comb begin
      skip_in = skip_ff;
      if (cmd.set_skip) skip_in = 1'b1;
      if (cmd.emit)     skip_in = 1'b0;
   end

   // result register
   logic [31:0] sy_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_step && sts.div_last && !cmd.div_sel_y)
         sy_ff <= neg_ff ? -half : half;
      if (cmd.emit) begin
         rsp_data[0]     <= jump_ff | skip_ff;
         rsp_data[32:1]  <= sx_ff;
         rsp_data[64:33] <= sy_ff;
         rsp_data[80:65] <= (jump_ff | skip_ff) ? 16'd0 : density;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) skip_ff <= 1'b0;
      else       skip_ff <= skip_in;
   end

endmodule

// File: src/wireframe_vertex_projector.sv
// Wireframe vertex projector top level: wvp_ctrl plus wvp_datapath, types from wvp_pkg.
// Load: a matrix entry is written when its beat is taken. A projection runs 9 MAC
// steps, a depth check and the shared divider for x then y before rsp_tvalid rises.
// Throughput: one item at a time; a skipped vertex frees the input after its depth
// check, a drawn one after the output state, later while the last result is unread.
// Reset is synchronous, active high: clears control, skip flag, density to 300.
module wireframe_vertex_projector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // op, row[2], col[2], value[32], x, y, z[16], pad
   input  logic        req_tuser,  // jump_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // is_move, screen_x, screen_y, density_out, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data    // line_density
);
   import wvp_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] dens_ff;
   logic [80:0] rdata;

   assign csr_ready = 1'b1;
   // density register
   always_ff @(posedge clock) begin
      if (reset)          dens_ff <= 16'd300;
      else if (csr_valid) dens_ff <= csr_data;
   end

   wvp_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tdata[0]),
      .rsp_tvalid, .rsp_tready, .cmd, .sts
   );

   wvp_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .matrix_row(req_tdata[2:1]), .matrix_col(req_tdata[4:3]),
      .matrix_value(req_tdata[36:5]), .vert_x(req_tdata[52:37]),
      .vert_y(req_tdata[68:53]), .vert_z(req_tdata[84:69]),
      .jump_flag(req_tuser), .density(dens_ff), .rsp_data(rdata)
   );

   assign rsp_tdata = {7'd0, rdata};

endmodule
